// ----- design/rqts_pkg.sv -----
package rqts_pkg;

  // Default ready queue depth
  localparam int unsigned NUM_TASKS = 4;

  // Task ids, deadlines and periods
  localparam int unsigned NUM_IDS  = 4;
  localparam int unsigned ID_W     = 2;
  localparam int unsigned DL_W     = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned POLICY_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QCOUNT_W   = 3;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [DL_W-1:0]     deadline_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [POLICY_W-1:0] policy_t;

  // Period register reset values
  localparam period_t PERIOD_RESET [NUM_IDS] = '{
    PERIOD_W'(1000), PERIOD_W'(2000), PERIOD_W'(4000), PERIOD_W'(6000)
  };

  // Selection policy codes; the unused code falls back to FIFO
  typedef enum logic [POLICY_W-1:0] {
    POL_FIFO = 2'd0,
    POL_EDF  = 2'd1,
    POL_RM   = 2'd2
  } policy_e;

  // Input command codes
  typedef enum logic {
    CMD_RELEASE = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY  = 3'd0,
    CFG_PERIOD0 = 3'd1,
    CFG_PERIOD1 = 3'd2,
    CFG_PERIOD2 = 3'd3,
    CFG_PERIOD3 = 3'd4
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  // Queue update request
  typedef struct packed {
    logic append;
    logic remove;
  } q_op_t;

endpackage

// ----- design/ready_queue_task_scheduler_unit.sv -----
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   cmd_i, task_id_i, abs_deadline_i, cpu_busy_i
// out      output     out_valid_o / out_stall_i dispatched_o, dispatched_id_o, queue_count_o,
//                                               release_dropped_o
// cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A release, or a tick that dispatches nothing, goes from IDLE to FINISH; a dispatching
// tick first walks each queued entry in WALK through the single key comparator.
// The next item is taken once the result sits in the output register.
// Reset empties the queue and loads the register defaults; queue entries and
// deadlines hold no value until written. A stalled output holds the block in FINISH.
module ready_queue_task_scheduler_unit #(
  parameter int unsigned NumTasks = rqts_pkg::NUM_TASKS,
  localparam int unsigned IdxW = $clog2(NumTasks),
  localparam int unsigned CntW = $clog2(NumTasks + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  rqts_pkg::id_t                 task_id_i,
  input  rqts_pkg::deadline_t           abs_deadline_i,
  input  logic                          cpu_busy_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          dispatched_o,
  output rqts_pkg::id_t                 dispatched_id_o,
  output logic [rqts_pkg::QCOUNT_W-1:0] queue_count_o,
  output logic                          release_dropped_o,
  input  logic                          cfg_we_i,
  input  logic [rqts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rqts_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rqts_pkg::*;

  state_e state_q, state_d;

  policy_t                   policy_q;
  period_t [NUM_IDS-1:0]     period_q;

  logic      rel_q;
  logic      disp_q;
  id_t       tid_q;
  deadline_t dl_q;

  logic                out_valid_q;
  logic                dispatched_q;
  id_t                 disp_id_q;
  logic [QCOUNT_W-1:0] qcount_q;
  logic                dropped_q;

  logic            accept;
  logic            dispatch_now;
  logic            pick_start;
  logic            pick_step;
  logic            out_free;
  logic            fire;
  logic            full;
  q_op_t           q_op;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_after;

  logic [IdxW-1:0] rd_idx;
  id_t             rd_id;
  deadline_t       rd_deadline;
  logic            last;
  logic [IdxW-1:0] best_idx;
  id_t             best_id;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
      for (int i = 0; i < NUM_IDS; i++) begin
        period_q[i] <= PERIOD_RESET[i];
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POLICY:  policy_q    <= cfg_data_i[POLICY_W-1:0];
        CFG_PERIOD0: period_q[0] <= cfg_data_i[PERIOD_W-1:0];
        CFG_PERIOD1: period_q[1] <= cfg_data_i[PERIOD_W-1:0];
        CFG_PERIOD2: period_q[2] <= cfg_data_i[PERIOD_W-1:0];
        CFG_PERIOD3: period_q[3] <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign full         = (count == CntW'(NumTasks));
  assign dispatch_now = (cmd_i == CMD_TICK) && !cpu_busy_i && (count != '0);
  assign out_free     = !out_valid_q || !out_stall_i;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = dispatch_now ? ST_WALK : ST_FINISH;
        end
      end
      ST_WALK: begin
        if (last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    accept      = 1'b0;
    pick_start  = 1'b0;
    pick_step   = 1'b0;
    fire        = 1'b0;
    in_stall_o  = 1'b1;
    q_op        = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
        pick_start = in_valid_i && dispatch_now;
      end
      ST_WALK: begin
        pick_step = 1'b1;
      end
      ST_FINISH: begin
        fire        = out_free;
        q_op.append = out_free && rel_q && !full;
        q_op.remove = out_free && disp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q  <= 1'b0;
      disp_q <= 1'b0;
    end else if (accept) begin
      rel_q  <= (cmd_i == CMD_RELEASE);
      disp_q <= dispatch_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tid_q <= task_id_i;
      dl_q  <= abs_deadline_i;
    end
  end

  // Count after this item's update
  always_comb begin
    if (disp_q) begin
      count_after = count - CntW'(1);
    end else if (rel_q && !full) begin
      count_after = count + CntW'(1);
    end else begin
      count_after = count;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dispatched_q <= disp_q;
      disp_id_q    <= disp_q ? best_id : '0;
      qcount_q     <= QCOUNT_W'(count_after);
      dropped_q    <= rel_q && full;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign dispatched_o      = dispatched_q;
  assign dispatched_id_o   = disp_id_q;
  assign queue_count_o     = qcount_q;
  assign release_dropped_o = dropped_q;

  rqts_queue #(
    .Depth (NumTasks)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (q_op),
    .wr_id_i       (tid_q),
    .wr_deadline_i (dl_q),
    .rm_pos_i      (best_idx),
    .rd_idx_i      (rd_idx),
    .rd_id_o       (rd_id),
    .rd_deadline_o (rd_deadline),
    .count_o       (count)
  );

  rqts_pick #(
    .Depth (NumTasks)
  ) u_pick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (pick_start),
    .step_i        (pick_step),
    .policy_i      (policy_q),
    .count_i       (count),
    .period_i      (period_q),
    .rd_id_i       (rd_id),
    .rd_deadline_i (rd_deadline),
    .rd_idx_o      (rd_idx),
    .last_o        (last),
    .best_idx_o    (best_idx),
    .best_id_o     (best_id)
  );

endmodule

// ----- design/rqts_queue.sv -----
module rqts_queue #(
  parameter int unsigned Depth = rqts_pkg::NUM_TASKS,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rqts_pkg::q_op_t     op_i,
  input  rqts_pkg::id_t       wr_id_i,
  input  rqts_pkg::deadline_t wr_deadline_i,
  input  logic [IdxW-1:0]     rm_pos_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output rqts_pkg::id_t       rd_id_o,
  output rqts_pkg::deadline_t rd_deadline_o,
  output logic [CntW-1:0]     count_o
);
  import rqts_pkg::*;

  id_t             entry_q [Depth];
  deadline_t       dl_q    [NUM_IDS];
  logic [CntW-1:0] count_q;

  // Track the number of queued entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (op_i.append) begin
      count_q <= count_q + CntW'(1);
    end else if (op_i.remove) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // Append at the tail, or close the gap left by a removed entry
  always_ff @(posedge clk_i) begin
    if (op_i.append) begin
      entry_q[count_q[IdxW-1:0]] <= wr_id_i;
    end else if (op_i.remove) begin
      for (int i = 0; i < Depth - 1; i++) begin
        if (IdxW'(i) >= rm_pos_i) begin
          entry_q[i] <= entry_q[i+1];
        end
      end
    end
  end

  // Record the deadline of the released task
  always_ff @(posedge clk_i) begin
    if (op_i.append) begin
      dl_q[wr_id_i] <= wr_deadline_i;
    end
  end

  assign rd_id_o       = entry_q[rd_idx_i];
  assign rd_deadline_o = dl_q[rd_id_o];
  assign count_o       = count_q;

endmodule

// ----- design/rqts_pick.sv -----
module rqts_pick #(
  parameter int unsigned Depth = rqts_pkg::NUM_TASKS,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic                                        step_i,
  input  rqts_pkg::policy_t                           policy_i,
  input  logic [CntW-1:0]                             count_i,
  input  rqts_pkg::period_t [rqts_pkg::NUM_IDS-1:0]   period_i,
  input  rqts_pkg::id_t                               rd_id_i,
  input  rqts_pkg::deadline_t                         rd_deadline_i,
  output logic [IdxW-1:0]                             rd_idx_o,
  output logic                                        last_o,
  output logic [IdxW-1:0]                             best_idx_o,
  output rqts_pkg::id_t                               best_id_o
);
  import rqts_pkg::*;

  logic [IdxW-1:0] idx_q;
  deadline_t       best_key_q;
  logic [IdxW-1:0] best_idx_q;
  id_t             best_id_q;

  deadline_t key;
  logic      use_key;
  logic      take;

  // Form the key of the current entry and compare it with the best so far
  always_comb begin
    use_key = (policy_i == POL_EDF) || (policy_i == POL_RM);
    if (policy_i == POL_EDF) begin
      key = rd_deadline_i;
    end else if (policy_i == POL_RM) begin
      key = DL_W'(period_i[rd_id_i]);
    end else begin
      key = '0;
    end
    // Only a strictly smaller key replaces the choice, so ties keep the older entry
    take = (idx_q == '0) || (use_key && (key < best_key_q));
  end

  // Advance the walk one queue entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (start_i) begin
      idx_q <= '0;
    end else if (step_i) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // Hold the running minimum
  always_ff @(posedge clk_i) begin
    if (step_i && take) begin
      best_key_q <= key;
      best_idx_q <= idx_q;
      best_id_q  <= rd_id_i;
    end
  end

  assign rd_idx_o   = idx_q;
  assign last_o     = (CntW'(idx_q) == (count_i - CntW'(1)));
  assign best_idx_o = best_idx_q;
  assign best_id_o  = best_id_q;

endmodule
